// ===== hdl/ctk_pkg.sv =====
// Shared constants, codes and types of the channel scan top-k tracker.
package ctk_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

  localparam int CHAN_W     = 16;
  localparam int STR_W      = 16;
  localparam int NOW_W      = CHAN_W + 1;
  localparam int OP_W       = 3;
  localparam int STAT_W     = 2;
  localparam int EIDX_W     = 5;
  localparam int CFG_LEN_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_START   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 3'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ABORT   = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_TUNE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FINISH = 2'd1;
  localparam logic [STAT_W-1:0] STAT_IDLE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_LEN = 2'd2;

  typedef struct packed {
    logic start;
    logic advance;
    logic abort;
  } scan_cmd_t;

  typedef struct packed {
    logic clear;
    logic sort_go;
    logic read_go;
  } list_cmd_t;

  typedef struct packed {
    logic              done;
    logic              entry_valid;
    logic [CHAN_W-1:0] entry_channel;
    logic [STR_W-1:0]  entry_strength;
  } list_rsp_t;

endpackage

// ===== hdl/ctk_scan.sv =====
// Scan position registers and the advance step.
module ctk_scan import ctk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_cmd_t         cmd_i,
  input  logic [CHAN_W-1:0] start_channel_i,
  input  logic [CHAN_W-1:0] scan_min_i,
  input  logic [CHAN_W-1:0] scan_max_i,
  output logic [STAT_W-1:0] adv_status_o,
  output logic [CHAN_W-1:0] adv_tune_o,
  output logic              scanning_o,
  output logic              scanning_d_o,
  output logic [CHAN_W-1:0] current_d_o
);

  logic              active_q, active_d;
  logic [NOW_W-1:0]  now_q, now_d;
  logic [NOW_W-1:0]  stop_q, stop_d;
  logic [CHAN_W-1:0] first_q, first_d;

  logic              adv_active;
  logic [NOW_W-1:0]  adv_now, adv_stop, nxt, wrap, max_x, first_x;
  logic [STAT_W-1:0] adv_status;
  logic [CHAN_W-1:0] adv_tune;

  assign nxt     = now_q + NOW_W'(1);
  assign wrap    = {1'b0, scan_min_i};
  assign max_x   = {1'b0, scan_max_i};
  assign first_x = {1'b0, first_q};

  always_comb begin
    adv_active = active_q;
    adv_now    = now_q;
    adv_stop   = stop_q;
    adv_status = STAT_TUNE;
    adv_tune   = '0;
    if (!active_q) begin
      adv_status = STAT_IDLE;
    end else if (nxt > stop_q) begin
      adv_active = 1'b0;
      adv_status = STAT_FINISH;
    end else if (nxt > max_x) begin
      // wrap to the bottom of the range, stop once the start channel is passed
      adv_stop = first_x;
      if (wrap > first_x || wrap > max_x) begin
        adv_now    = wrap - NOW_W'(1);
        adv_active = 1'b0;
        adv_status = STAT_FINISH;
      end else begin
        adv_now  = wrap;
        adv_tune = scan_min_i;
      end
    end else begin
      adv_now  = nxt;
      adv_tune = nxt[CHAN_W-1:0];
    end
  end

  always_comb begin
    active_d = active_q;
    now_d    = now_q;
    stop_d   = stop_q;
    first_d  = first_q;
    if (cmd_i.start) begin
      active_d = 1'b1;
      first_d  = start_channel_i;
      now_d    = {1'b0, start_channel_i};
      stop_d   = max_x + NOW_W'(1);
    end else if (cmd_i.advance) begin
      active_d = adv_active;
      now_d    = adv_now;
      stop_d   = adv_stop;
    end else if (cmd_i.abort) begin
      active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      now_q    <= '0;
      stop_q   <= '0;
      first_q  <= '0;
    end else begin
      active_q <= active_d;
      now_q    <= now_d;
      stop_q   <= stop_d;
      first_q  <= first_d;
    end
  end

  assign adv_status_o = adv_status;
  assign adv_tune_o   = adv_tune;
  assign scanning_o   = active_q;
  assign scanning_d_o = active_d;
  assign current_d_o  = now_d[CHAN_W-1:0];

endmodule

// ===== hdl/ctk_list.sv =====
// Best-channel list: entry memory, valid bits, the insertion sequencer and the entry read.
module ctk_list import ctk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  list_cmd_t         cmd_i,
  input  logic [LEN_W-1:0]  eff_len_i,
  input  logic [STR_W-1:0]  strength_i,
  input  logic [CHAN_W-1:0] channel_i,
  input  logic [EIDX_W-1:0] index_i,
  output list_rsp_t         rsp_o
);

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [STR_W-1:0]  str;
  } entry_t;

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_READ  = 3'd1;
  localparam logic [2:0] L_CHECK = 3'd2;
  localparam logic [2:0] L_WALK  = 3'd3;
  localparam logic [2:0] L_PUT   = 3'd4;

  entry_t mem [LIST_DEPTH];
  entry_t rd_data_q;

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      pos_q, pos_d, pos_m1;
  logic [LIST_DEPTH-1:0] valid_q;
  logic                  range_q;
  logic                  ev_q;
  logic [CHAN_W-1:0]     ech_q;
  logic [STR_W-1:0]      est_q;

  logic             rd_en, wr_en, wr_valid, done;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           wr_data, new_entry;
  logic [LEN_W-1:0] last;
  logic             in_range;

  assign pos_m1    = pos_q - IDX_W'(1);
  assign last      = eff_len_i - LEN_W'(1);
  assign new_entry = '{chan: channel_i, str: strength_i};
  assign in_range  = ({1'b0, index_i} < (EIDX_W + 1)'(eff_len_i));

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    rd_en    = 1'b0;
    rd_addr  = pos_q;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = new_entry;
    wr_valid = 1'b1;
    done     = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        if (cmd_i.sort_go) begin
          pos_d   = last[IDX_W-1:0];
          rd_en   = 1'b1;
          rd_addr = last[IDX_W-1:0];
          state_d = L_CHECK;
        end else if (cmd_i.read_go) begin
          pos_d   = index_i[IDX_W-1:0];
          rd_en   = 1'b1;
          rd_addr = index_i[IDX_W-1:0];
          state_d = L_READ;
        end
      end
      L_READ: begin
        done    = 1'b1;
        state_d = L_IDLE;
      end
      L_CHECK: begin
        // not stronger than the weakest kept entry: drop the item
        if (valid_q[pos_q] && strength_i <= rd_data_q.str) begin
          done    = 1'b1;
          state_d = L_IDLE;
        end else if (pos_q == '0) begin
          wr_en   = 1'b1;
          done    = 1'b1;
          state_d = L_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_m1;
          state_d = L_WALK;
        end
      end
      L_WALK: begin
        // rd_data_q holds the entry above pos_q; move it down if weaker
        if (!valid_q[pos_m1] || rd_data_q.str < strength_i) begin
          wr_en    = 1'b1;
          wr_data  = rd_data_q;
          wr_valid = valid_q[pos_m1];
          pos_d    = pos_m1;
          if (pos_m1 == '0) begin
            state_d = L_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_q - IDX_W'(2);
          end
        end else begin
          wr_en   = 1'b1;
          done    = 1'b1;
          state_d = L_IDLE;
        end
      end
      L_PUT: begin
        wr_en   = 1'b1;
        done    = 1'b1;
        state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      pos_q   <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (wr_en) begin
        valid_q[wr_addr] <= wr_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && cmd_i.read_go) begin
      range_q <= in_range;
    end
    if (state_q == L_READ) begin
      ev_q  <= range_q && valid_q[pos_q];
      ech_q <= (range_q && valid_q[pos_q]) ? rd_data_q.chan : '0;
      est_q <= (range_q && valid_q[pos_q]) ? rd_data_q.str : '0;
    end
  end

  assign rsp_o.done           = done;
  assign rsp_o.entry_valid    = ev_q;
  assign rsp_o.entry_channel  = ech_q;
  assign rsp_o.entry_strength = est_q;

endmodule

// ===== hdl/channel_scan_top_k_tracker_unit.sv =====
// Channel scan top-k tracker: command decode, configuration and result register.
//
// One item is taken at a time and gives one result. Start, advance, abort and
// unknown commands go from acceptance through the execute and hold states to a
// loaded result; a read also passes through the synchronous list memory. A
// strength sample taken while not scanning goes from execute straight to hold.
// A sample during a scan walks the sorted list one entry per cycle from the
// last kept position upward, bound by the single read port of the list memory.
// A result that waits on the output register holds off the next completion,
// not the acceptance of the next item. Start empties the list at once through
// per-entry valid bits; no clearing pass is needed after reset.
module channel_scan_top_k_tracker_unit import ctk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [CHAN_W-1:0]     start_channel_i,
  input  logic [STR_W-1:0]      strength_i,
  input  logic [EIDX_W-1:0]     entry_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STAT_W-1:0]     status_o,
  output logic                  tune_valid_o,
  output logic [CHAN_W-1:0]     tune_channel_o,
  output logic                  scanning_o,
  output logic [CHAN_W-1:0]     current_channel_o,
  output logic                  entry_valid_o,
  output logic [CHAN_W-1:0]     entry_channel_o,
  output logic [STR_W-1:0]      entry_strength_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0] state_q, state_d;

  logic [CHAN_W-1:0]    scan_min_q, scan_max_q;
  logic [CFG_LEN_W-1:0] list_len_q;
  logic [LEN_W-1:0]     eff_len;

  logic [OP_W-1:0]   op_q;
  logic [CHAN_W-1:0] start_q;
  logic [STR_W-1:0]  str_q;
  logic [EIDX_W-1:0] idx_q;

  logic accept, out_free, load;

  scan_cmd_t         scan_cmd;
  list_cmd_t         list_cmd;
  list_rsp_t         list_rsp;
  logic [STAT_W-1:0] adv_status;
  logic [CHAN_W-1:0] adv_tune;
  logic              scan_active, scanning_d;
  logic [CHAN_W-1:0] current_d;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic              tune_valid_q;
  logic [CHAN_W-1:0] tune_channel_q;
  logic              scanning_q;
  logic [CHAN_W-1:0] current_q;
  logic              ev_q;
  logic [CHAN_W-1:0] ech_q;
  logic [STR_W-1:0]  est_q;

  logic is_adv, is_read;

  // clamp list_len to 1..LIST_DEPTH
  always_comb begin
    if (list_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if ({{(32-CFG_LEN_W){1'b0}}, list_len_q} > LIST_DEPTH) begin
      eff_len = LEN_W'(LIST_DEPTH);
    end else begin
      eff_len = LEN_W'(list_len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_min_q <= '0;
      scan_max_q <= '1;
      list_len_q <= CFG_LEN_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCAN_MIN: scan_min_q <= cfg_data_i[CHAN_W-1:0];
        CFG_SCAN_MAX: scan_max_q <= cfg_data_i[CHAN_W-1:0];
        CFG_LIST_LEN: list_len_q <= cfg_data_i[CFG_LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_adv     = (op_q == OP_ADVANCE);
  assign is_read    = (op_q == OP_READ);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      start_q <= start_channel_i;
      str_q   <= strength_i;
      idx_q   <= entry_index_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    scan_cmd = '0;
    list_cmd = '0;
    load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (op_q)
          OP_SAMPLE: begin
            if (scan_active) begin
              list_cmd.sort_go = 1'b1;
              state_d          = S_LIST;
            end else begin
              state_d = S_HOLD;
            end
          end
          OP_READ: begin
            list_cmd.read_go = 1'b1;
            state_d          = S_LIST;
          end
          default: state_d = S_HOLD;
        endcase
      end
      S_LIST: begin
        if (list_rsp.done) state_d = S_HOLD;
      end
      S_HOLD: begin
        // scan state commits together with the result load
        if (out_free) begin
          load             = 1'b1;
          scan_cmd.start   = (op_q == OP_START);
          scan_cmd.advance = is_adv;
          scan_cmd.abort   = (op_q == OP_ABORT);
          list_cmd.clear   = (op_q == OP_START);
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q       <= is_adv ? adv_status : STAT_TUNE;
      tune_valid_q   <= is_adv && (adv_status == STAT_TUNE);
      tune_channel_q <= (is_adv && (adv_status == STAT_TUNE)) ? adv_tune : '0;
      scanning_q     <= scanning_d;
      current_q      <= current_d;
      ev_q           <= is_read && list_rsp.entry_valid;
      ech_q          <= is_read ? list_rsp.entry_channel : '0;
      est_q          <= is_read ? list_rsp.entry_strength : '0;
    end
  end

  ctk_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (scan_cmd),
    .start_channel_i (start_q),
    .scan_min_i      (scan_min_q),
    .scan_max_i      (scan_max_q),
    .adv_status_o    (adv_status),
    .adv_tune_o      (adv_tune),
    .scanning_o      (scan_active),
    .scanning_d_o    (scanning_d),
    .current_d_o     (current_d)
  );

  ctk_list u_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (list_cmd),
    .eff_len_i  (eff_len),
    .strength_i (str_q),
    .channel_i  (current_d),
    .index_i    (idx_q),
    .rsp_o      (list_rsp)
  );

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign tune_valid_o      = tune_valid_q;
  assign tune_channel_o    = tune_channel_q;
  assign scanning_o        = scanning_q;
  assign current_channel_o = current_q;
  assign entry_valid_o     = ev_q;
  assign entry_channel_o   = ech_q;
  assign entry_strength_o  = est_q;

endmodule

// ===== hdl/ctk_checker.sv =====
// Port-level checks of the tracker and their binding to the top level.
module ctk_checker import ctk_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [STAT_W-1:0]     status_o,
  input logic                  tune_valid_o,
  input logic [CHAN_W-1:0]     tune_channel_o,
  input logic                  scanning_o,
  input logic [CHAN_W-1:0]     current_channel_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item in flight: the next cycle after an acceptance is stalled
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken while busy");

  // a tune result leaves the scan on the tuned channel
  a_tune_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tune_valid_o |-> scanning_o && current_channel_o == tune_channel_o
      && status_o == STAT_TUNE)
    else $error("tune result disagrees with scan position");

  // a finished scan is no longer scanning
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FINISH |-> !scanning_o && !tune_valid_o)
    else $error("finished scan still active");

endmodule

bind channel_scan_top_k_tracker_unit ctk_checker u_ctk_checker (.*);

// ===== tb/sv/tb.sv =====
// Testbench for channel_scan_top_k_tracker_unit: directed and random items against a scan/list predictor.
module tb;
  import ctk_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PHASES          = 7;
  localparam logic [OP_W-1:0]   OP_TOP   = '1;
  localparam logic [CHAN_W-1:0] CHAN_TOP = '1;
  localparam logic [STR_W-1:0]  STR_TOP  = '1;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              tune_valid;
    logic [CHAN_W-1:0] tune_channel;
    logic              scanning;
    logic [CHAN_W-1:0] current_channel;
    logic              entry_valid;
    logic [CHAN_W-1:0] entry_channel;
    logic [STR_W-1:0]  entry_strength;
  } scan_result_t;

  class scan_scoreboard;
    logic [CHAN_W-1:0]    scan_min;
    logic [CHAN_W-1:0]    scan_max;
    logic [CFG_LEN_W-1:0] list_len;
    bit                   active;
    logic [NOW_W-1:0]     now_ch;
    logic [NOW_W-1:0]     stop_lim;
    logic [CHAN_W-1:0]    first_ch;
    logic [CHAN_W-1:0]    best_ch [LIST_DEPTH];
    int                   best_str [LIST_DEPTH];
    scan_result_t         expected_q [$];
    int                   errors;
    int                   results_seen;

    function new();
      scan_min = '0;
      scan_max = '1;
      list_len = CFG_LEN_W'(LIST_DEPTH);
      active = 1'b0;
      now_ch = '0;
      stop_lim = '0;
      first_ch = '0;
      errors = 0;
      results_seen = 0;
      clear_list();
    endfunction

    function void clear_list();
      for (int i = 0; i < LIST_DEPTH; i++) begin
        best_ch[i] = '1;
        best_str[i] = -1;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SCAN_MIN: scan_min = data;
        CFG_SCAN_MAX: scan_max = data;
        CFG_LIST_LEN: list_len = data[CFG_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int kept();
      int n;
      n = list_len;
      if (n < 1) n = 1;
      if (n > LIST_DEPTH) n = LIST_DEPTH;
      return n;
    endfunction

    function logic [STAT_W-1:0] step_channel(output logic [CHAN_W-1:0] tune);
      tune = '0;
      if (!active) return STAT_IDLE;
      now_ch = now_ch + 1'b1;
      if (now_ch <= stop_lim && now_ch > {1'b0, scan_max}) begin
        // past the top: wrap and climb back up to the start channel
        stop_lim = {1'b0, first_ch};
        now_ch = {1'b0, scan_min};
      end
      if (now_ch > stop_lim || now_ch > {1'b0, scan_max}) begin
        now_ch = now_ch - 1'b1;
        active = 1'b0;
        return STAT_FINISH;
      end
      tune = now_ch[CHAN_W-1:0];
      return STAT_TUNE;
    endfunction

    function void take_sample(logic [STR_W-1:0] s);
      int pos;
      int v;
      if (!active) return;
      pos = kept() - 1;
      v = s;
      if (v <= best_str[pos]) return;
      // ties stay below older equal entries
      while (pos > 0 && best_str[pos-1] < v) begin
        best_str[pos] = best_str[pos-1];
        best_ch[pos] = best_ch[pos-1];
        pos--;
      end
      best_str[pos] = v;
      best_ch[pos] = now_ch[CHAN_W-1:0];
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [CHAN_W-1:0] start,
                            logic [STR_W-1:0] s, logic [EIDX_W-1:0] idx);
      scan_result_t r;
      logic [CHAN_W-1:0] tune;
      r = '0;
      case (op)
        OP_START: begin
          active = 1'b1;
          first_ch = start;
          now_ch = {1'b0, start};
          stop_lim = {1'b0, scan_max} + 1'b1;
          clear_list();
        end
        OP_ADVANCE: begin
          r.status = step_channel(tune);
          r.tune_valid = (r.status == STAT_TUNE);
          r.tune_channel = tune;
        end
        OP_SAMPLE: take_sample(s);
        OP_ABORT: active = 1'b0;
        OP_READ: begin
          if (idx < kept() && best_str[idx] >= 0) begin
            r.entry_valid = 1'b1;
            r.entry_channel = best_ch[idx];
            r.entry_strength = STR_W'(best_str[idx]);
          end
        end
        default: ;
      endcase
      r.scanning = active;
      r.current_channel = now_ch[CHAN_W-1:0];
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task check_result(scan_result_t got);
      scan_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with no item waiting");
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.tune_valid !== want.tune_valid)
        report($sformatf("tune_valid %0d, expected %0d", got.tune_valid, want.tune_valid));
      if (got.tune_channel !== want.tune_channel)
        report($sformatf("tune_channel %0d, expected %0d",
                         got.tune_channel, want.tune_channel));
      if (got.scanning !== want.scanning)
        report($sformatf("scanning %0d, expected %0d", got.scanning, want.scanning));
      if (got.current_channel !== want.current_channel)
        report($sformatf("current_channel %0d, expected %0d",
                         got.current_channel, want.current_channel));
      if (got.entry_valid !== want.entry_valid)
        report($sformatf("entry_valid %0d, expected %0d", got.entry_valid, want.entry_valid));
      if (got.entry_channel !== want.entry_channel)
        report($sformatf("entry_channel %0d, expected %0d",
                         got.entry_channel, want.entry_channel));
      if (got.entry_strength !== want.entry_strength)
        report($sformatf("entry_strength %0d, expected %0d",
                         got.entry_strength, want.entry_strength));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       op_i = '0;
  logic [CHAN_W-1:0]     start_channel_i = '0;
  logic [STR_W-1:0]      strength_i = '0;
  logic [EIDX_W-1:0]     entry_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [STAT_W-1:0]     status_o;
  logic                  tune_valid_o;
  logic [CHAN_W-1:0]     tune_channel_o;
  logic                  scanning_o;
  logic [CHAN_W-1:0]     current_channel_o;
  logic                  entry_valid_o;
  logic [CHAN_W-1:0]     entry_channel_o;
  logic [STR_W-1:0]      entry_strength_o;

  scan_scoreboard sb;
  int items_sent = 0;
  int burst_left = 0;
  bit valid_high = 1'b0;
  int idle_cycles = 0;

  channel_scan_top_k_tracker_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .start_channel_i   (start_channel_i),
    .strength_i        (strength_i),
    .entry_index_i     (entry_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .tune_valid_o      (tune_valid_o),
    .tune_channel_o    (tune_channel_o),
    .scanning_o        (scanning_o),
    .current_channel_o (current_channel_o),
    .entry_valid_o     (entry_valid_o),
    .entry_channel_o   (entry_channel_o),
    .entry_strength_o  (entry_strength_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({status_o, tune_valid_o, tune_channel_o, scanning_o,
                       current_channel_o, entry_valid_o, entry_channel_o,
                       entry_strength_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("channel_scan_top_k_tracker_unit test failed");
      $finish;
    end
  end

  // receiver: random stall modes, plus two long hold-offs so the block backs up
  initial begin : receiver
    int mode;
    int len;
    int holds;
    holds = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ((holds == 0 && items_sent >= 200) || (holds == 1 && items_sent >= 480)) begin
        holds++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(4, 40);
      repeat (len) begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= $urandom_range(0, 1);
          2: out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [CHAN_W-1:0] ch,
                           logic [STR_W-1:0] st, logic [EIDX_W-1:0] idx);
    in_valid_i <= 1'b1;
    valid_high = 1'b1;
    op_i <= op;
    start_channel_i <= ch;
    strength_i <= st;
    entry_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, ch, st, idx);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      valid_high = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    if (valid_high) begin
      in_valid_i <= 1'b0;
      valid_high = 1'b0;
    end
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_ranges(logic [CHAN_W-1:0] lo, logic [CHAN_W-1:0] hi,
                            logic [CFG_LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] len_word;
    wait_idle();
    len_word = $urandom;
    len_word[CFG_LEN_W-1:0] = len;
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_SCAN_MIN;
    cfg_data_i <= lo;
    @(posedge clk_i);
    sb.set_reg(CFG_SCAN_MIN, lo);
    cfg_index_i <= CFG_SCAN_MAX;
    cfg_data_i <= hi;
    @(posedge clk_i);
    sb.set_reg(CFG_SCAN_MAX, hi);
    cfg_index_i <= CFG_LIST_LEN;
    cfg_data_i <= len_word;
    @(posedge clk_i);
    sb.set_reg(CFG_LIST_LEN, len_word);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    // nothing scanning yet
    send_item(OP_ADVANCE, '0, '0, '0);
    send_item(OP_SAMPLE, '0, STR_TOP, '0);
    for (int c = OP_READ + 1; c <= OP_TOP; c++) send_item(OP_W'(c), CHAN_TOP, STR_TOP, '1);
    // full range, start just under the top so the scan wraps to scan_min
    send_item(OP_START, CHAN_TOP - 1, '0, '0);
    send_item(OP_ADVANCE, '0, '0, '0);
    send_item(OP_ADVANCE, '0, '0, '0);
    send_item(OP_SAMPLE, '0, STR_TOP, '0);
    send_item(OP_SAMPLE, '0, '0, '0);
    send_item(OP_SAMPLE, '0, '0, '0);
    send_item(OP_READ, '0, '0, 0);
    send_item(OP_READ, '0, '0, 1);
    // restart mid-scan empties the list
    send_item(OP_START, CHAN_TOP, '0, '0);
    send_item(OP_READ, '0, '0, 0);
    send_item(OP_ABORT, '0, '0, '0);
    // min above max, one entry kept
    set_ranges(100, 50, 1);
    send_item(OP_START, 49, '0, '0);
    send_item(OP_ADVANCE, '0, '0, '0);
    send_item(OP_SAMPLE, '0, 7, '0);
    send_item(OP_SAMPLE, '0, 7, '0);
    send_item(OP_SAMPLE, '0, 8, '0);
    send_item(OP_READ, '0, '0, 0);
    send_item(OP_READ, '0, '0, 1);
    send_item(OP_ADVANCE, '0, '0, '0);
    // start above scan_max ends on the first advance
    send_item(OP_START, 60, '0, '0);
    send_item(OP_ADVANCE, '0, '0, '0);
  endtask

  task automatic send_random();
    int pick;
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] ch;
    logic [STR_W-1:0]  st;
    logic [EIDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    if (sb.active) begin
      if (pick < 30)      op = OP_ADVANCE;
      else if (pick < 70) op = OP_SAMPLE;
      else if (pick < 90) op = OP_READ;
      else if (pick < 94) op = OP_START;
      else if (pick < 97) op = OP_ABORT;
      else                op = $urandom_range(OP_READ + 1, OP_TOP);
    end else begin
      if (pick < 50)      op = OP_START;
      else if (pick < 80) op = OP_READ;
      else if (pick < 88) op = OP_ADVANCE;
      else if (pick < 95) op = OP_SAMPLE;
      else if (pick < 97) op = OP_ABORT;
      else                op = $urandom_range(OP_READ + 1, OP_TOP);
    end
    case ($urandom_range(0, 9))
      0: ch = $urandom;
      1: ch = sb.scan_max;
      2: ch = sb.scan_min;
      3: ch = $urandom_range(0, 1) ? CHAN_TOP : '0;
      default: ch = (sb.scan_min <= sb.scan_max) ?
                    $urandom_range(sb.scan_min, sb.scan_max) : $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: st = $urandom;
      1: st = $urandom_range(0, 7);  // many ties
      2: st = $urandom_range(0, 1) ? STR_TOP : '0;
      default: st = $urandom_range(1000, 1100);
    endcase
    idx = $urandom_range(0, 1) ? $urandom_range(0, sb.kept() - 1) : $urandom;
    send_item(op, ch, st, idx);
  endtask

  initial begin : stimulus
    logic [CHAN_W-1:0] lo;
    logic [CHAN_W-1:0] hi;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_ranges('0, CHAN_TOP, CFG_LEN_W'(LIST_DEPTH));
        1: set_ranges(CHAN_TOP - 15, CHAN_TOP, 1);
        2: set_ranges(0, 24, 0);       // zero length acts as one entry
        3: set_ranges(1000, 1030, '1); // longer than the list, acts as full depth
        4: set_ranges(300, 280, 5);
        default: begin
          lo = $urandom;
          hi = (lo > CHAN_TOP - 40) ? CHAN_TOP : lo + $urandom_range(0, 40);
          set_ranges(lo, hi, $urandom_range(1, LIST_DEPTH));
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_random();
    end
    wait_idle();
    if (sb.expected_q.size() != 0) sb.report("results missing at end of run");
    if (sb.errors == 0) $display("channel_scan_top_k_tracker_unit test passed");
    else $display("channel_scan_top_k_tracker_unit test failed");
    $finish;
  end

endmodule
